// ----- rtl/htw_pkg.sv -----
// shared types and constants of the timer wheel
package htw_pkg;
	localparam int POOL_SIZE = 64;
	localparam int FIRST_LEVEL_BITS = 8;
	localparam int UPPER_LEVEL_BITS = 6;
	localparam int LEVEL_COUNT = 5;
	localparam int FIRST_SIZE = 1 << FIRST_LEVEL_BITS;
	localparam int UPPER_SIZE = 1 << UPPER_LEVEL_BITS;
	localparam int BUCKET_TOTAL = FIRST_SIZE + (LEVEL_COUNT - 1) * UPPER_SIZE;
	localparam int BW = $clog2(BUCKET_TOTAL);
	localparam int IW = 7;
	localparam int LW = $clog2(LEVEL_COUNT);
	localparam int UW = $clog2(LEVEL_COUNT - 1);

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_ADD = 3'd1;
	localparam logic [2:0] CMD_MODIFY = 3'd2;
	localparam logic [2:0] CMD_DELETE = 3'd3;
	localparam logic [2:0] CMD_GET = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_ID = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_EXPIRED = 3'd4;
	localparam logic [2:0] ST_EMPTY_TICK = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_ALLOC, S_PLACE_RD, S_PLACE_WT, S_LINK,
		S_UNL_RD, S_UNL_WT, S_UNL_P, S_UNL_N, S_UNL_DONE,
		S_CAS_RD, S_CAS_WT, S_CAS_NEXT, S_CAS_NWT, S_CAS_END,
		S_EMIT_RD, S_EMIT_WT, S_EMIT_NX, S_EMIT_NWT, S_TICK_END, S_GET_WT
	} state_t;

	// bucket of a timer given its expiry, the current tick and the first-level index
	function automatic logic [BW-1:0] bucket_of(input logic [31:0] e, input logic [31:0] now,
		input logic [FIRST_LEVEL_BITS-1:0] idx0);
		logic [31:0] d;
		logic [BW-1:0] b;
		logic [63:0] sh;
		d = e - now;
		sh = {32'd0, e};
		b = BW'(FIRST_SIZE + (LEVEL_COUNT - 2) * UPPER_SIZE)
			+ BW'((sh >> (FIRST_LEVEL_BITS + (LEVEL_COUNT - 2) * UPPER_LEVEL_BITS))
			& (UPPER_SIZE - 1));
		for (int k = LEVEL_COUNT - 2; k >= 1; k--) begin
			if ({32'd0, d} < (64'd1 << (FIRST_LEVEL_BITS + k * UPPER_LEVEL_BITS)))
				b = BW'(FIRST_SIZE + (k - 1) * UPPER_SIZE)
					+ BW'((sh >> (FIRST_LEVEL_BITS + (k - 1) * UPPER_LEVEL_BITS))
					& (UPPER_SIZE - 1));
		end
		if (d < 32'(FIRST_SIZE)) b = BW'(e[FIRST_LEVEL_BITS-1:0]);
		if (d[31]) b = BW'(idx0);
		return b;
	endfunction
endpackage

// ----- rtl/hierarchical_timer_wheel.sv -----
// top level of the five-level timer wheel
// One request at a time: busy is high from the accepting edge until the last result has
// been shown. After reset a clearing pass walks the 512 bucket head/tail words, one a
// cycle, with busy high throughout. Bad id, not found, pool full and unknown commands
// answer in the accepting cycle itself and busy never rises. An add searches the pool
// for a free id after the last one given, skipping live ids; a tick expires the timers
// of the current first-level bucket, and when the first-level index is 0 it first
// cascades upper-level buckets, moving each of their timers. Linking and unlinking also
// rewrite a neighbour's link word where one exists, and every list step waits on the
// registered read of the slot and bucket memories. Expiry results are held one step so
// that the final one carries last. Results come with strobe and cannot be stalled.
module hierarchical_timer_wheel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [6:0]  timer_id,
	input  logic [31:0] timeout,
	input  logic [31:0] user_tag,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [6:0]  result_id,
	output logic [31:0] result_tag,
	output logic        last
);
	import htw_pkg::*;

	// slot word: expiry, next, prev, bucket
	localparam int SW = 32 + IW + IW + BW;

	state_t st_q, st_d;
	logic [POOL_SIZE:0] live_q, live_d;
	logic [31:0] tick_q, tick_d;
	logic [FIRST_LEVEL_BITS-1:0] idx0_q, idx0_d;
	logic [UPPER_LEVEL_BITS-1:0] idxu_q [LEVEL_COUNT-1], idxu_d [LEVEL_COUNT-1];
	logic [IW-1:0] lastid_q, lastid_d, livecnt_q, livecnt_d;
	logic [BW-1:0] clr_q, clr_d;
	logic [2:0] cmd_q, cmd_d;
	logic [IW-1:0] id_q, id_d, nid_q, nid_d;
	logic [31:0] exp_q, exp_d, tag_q, tag_d;
	logic [LW-1:0] lvl_q, lvl_d;
	logic [BW-1:0] bk_q, bk_d;
	logic [IW-1:0] p_q, p_d, n_q, n_d;
	logic [6:0] emitn_q, emitn_d;

	// slot ram
	logic s_we; logic [5:0] s_wa, s_ra; logic [SW-1:0] s_wd, s_rd;
	logic t_we; logic [5:0] t_wa, t_ra; logic [31:0] t_wd, t_rd;
	// bucket ram: {first, final}
	logic b_we; logic [BW-1:0] b_wa, b_ra; logic [2*IW-1:0] b_wd, b_rd;

	htw_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_slot (.clk, .we(s_we), .waddr(s_wa),
		.wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	htw_ram #(.WIDTH(32), .DEPTH(POOL_SIZE)) u_tag (.clk, .we(t_we), .waddr(t_wa),
		.wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	htw_ram #(.WIDTH(2*IW), .DEPTH(BUCKET_TOTAL)) u_bkt (.clk, .we(b_we), .waddr(b_wa),
		.wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

	logic [31:0] rd_exp; logic [IW-1:0] rd_next, rd_prev; logic [BW-1:0] rd_bk;
	assign {rd_exp, rd_next, rd_prev, rd_bk} = s_rd;
	logic [IW-1:0] b_first, b_final;
	assign {b_first, b_final} = b_rd;

	function automatic logic [5:0] sa(input logic [IW-1:0] i);
		return 6'(i - 7'd1);
	endfunction

	// the slot ram has one write port, so partial updates of next/prev keep the other
	// fields by rewriting the whole word read just before
	logic [IW-1:0] cand;
	logic [BW-1:0] casb;
	logic [UW-1:0] uix;

	always_comb begin
		st_d = st_q; live_d = live_q; tick_d = tick_q; idx0_d = idx0_q; idxu_d = idxu_q;
		lastid_d = lastid_q; livecnt_d = livecnt_q; clr_d = clr_q; cmd_d = cmd_q;
		id_d = id_q; nid_d = nid_q; exp_d = exp_q; tag_d = tag_q; lvl_d = lvl_q;
		bk_d = bk_q; p_d = p_q; n_d = n_q; emitn_d = emitn_q;
		s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = sa(id_q);
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = sa(id_q);
		b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = bk_q;
		strobe = 1'b0; status = ST_OK; result_id = '0; result_tag = '0; last = 1'b0;
		cand = (lastid_q >= IW'(POOL_SIZE)) ? IW'(1) : lastid_q + IW'(1);
		uix = UW'(lvl_q - LW'(1));
		casb = BW'(FIRST_SIZE) + BW'(lvl_q - LW'(1)) * BW'(UPPER_SIZE)
			+ BW'(idxu_q[uix]);
		busy = (st_q != S_IDLE);
		case (st_q)
			S_CLEAR: begin
				b_we = 1'b1; b_wa = clr_q; b_wd = '0;
				clr_d = clr_q + BW'(1);
				if (clr_q == BW'(BUCKET_TOTAL - 1)) st_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd_d = cmd; id_d = timer_id; tag_d = user_tag;
					exp_d = tick_q + timeout;
					case (cmd)
						CMD_TICK: begin
							emitn_d = '0;
							if (idx0_q == '0) begin
								lvl_d = LW'(1); st_d = S_CAS_RD;
							end else begin
								bk_d = BW'(idx0_q); st_d = S_EMIT_RD;
							end
						end
						CMD_ADD: begin
							if (livecnt_q >= IW'(POOL_SIZE)) begin
								strobe = 1'b1; status = ST_FULL; last = 1'b1;
							end else begin
								lastid_d = lastid_q; st_d = S_ALLOC;
							end
						end
						CMD_MODIFY, CMD_DELETE, CMD_GET: begin
							if (timer_id == '0) begin
								strobe = 1'b1; status = ST_BAD_ID; last = 1'b1;
							end else if (timer_id > IW'(POOL_SIZE) || !live_q[timer_id]) begin
								strobe = 1'b1; status = ST_NOT_FOUND; last = 1'b1;
							end else if (cmd == CMD_GET) begin
								st_d = S_GET_WT;
							end else begin
								st_d = S_UNL_RD;
							end
						end
						default: begin
							strobe = 1'b1; status = ST_BAD_ID; last = 1'b1;
						end
					endcase
				end
			end
			S_GET_WT: st_d = S_UNL_DONE;
			S_ALLOC: begin
				// one candidate a cycle, wraps over the pool
				lastid_d = cand;
				if (!live_q[cand]) begin
					id_d = cand; live_d[cand] = 1'b1; livecnt_d = livecnt_q + IW'(1);
					t_we = 1'b1; t_wa = sa(cand); t_wd = tag_q;
					bk_d = bucket_of(exp_q, tick_q, idx0_q);
					st_d = S_PLACE_RD;
				end
			end
			S_PLACE_RD: st_d = S_PLACE_WT;
			S_PLACE_WT: begin
				// bucket word read; tail of list is p
				p_d = b_final; n_d = b_first;
				st_d = S_LINK;
			end
			S_LINK: begin
				s_we = 1'b1; s_wa = sa(id_q); s_wd = {exp_q, IW'(0), p_q, bk_q};
				b_we = 1'b1; b_wa = bk_q;
				b_wd = {(p_q == '0) ? id_q : n_q, id_q};
				if (p_q != '0) begin
					// previous tail gets its next pointer: read it first
					s_ra = sa(p_q);
					st_d = S_UNL_WT;
				end else begin
					st_d = S_UNL_DONE;
				end
			end
			S_UNL_WT: begin
				// previous tail word available: rewrite with next = linked id
				s_we = 1'b1; s_wa = sa(p_q);
				s_wd = {rd_exp, id_q, rd_prev, rd_bk};
				st_d = S_UNL_DONE;
			end
			S_UNL_RD: begin
				s_ra = sa(id_q); st_d = S_UNL_P;
			end
			S_UNL_P: begin
				// own word read: fetch bucket word
				p_d = rd_prev; n_d = rd_next; bk_d = rd_bk; exp_d = (cmd_q == CMD_MODIFY)
					? exp_q : rd_exp;
				b_ra = rd_bk;
				if (rd_prev != '0) s_ra = sa(rd_prev);
				st_d = S_UNL_N;
			end
			S_UNL_N: begin
				logic [IW-1:0] nf, nl;
				nf = (p_q == '0) ? n_q : b_first;
				nl = (n_q == '0) ? p_q : b_final;
				b_we = 1'b1; b_wa = bk_q; b_wd = {nf, nl};
				if (p_q != '0) begin
					s_we = 1'b1; s_wa = sa(p_q); s_wd = {rd_exp, n_q, rd_prev, rd_bk};
				end
				if (n_q != '0) begin
					s_ra = sa(n_q); st_d = S_CAS_NWT;
				end else begin
					st_d = S_CAS_END;
				end
			end
			S_CAS_NWT: begin
				// next word read: fix its prev
				s_we = 1'b1; s_wa = sa(n_q); s_wd = {rd_exp, rd_next, p_q, rd_bk};
				st_d = S_CAS_END;
			end
			S_CAS_END: begin
				// unlink finished; continue per command
				case (cmd_q)
					CMD_DELETE: begin
						live_d[id_q] = 1'b0; livecnt_d = livecnt_q - IW'(1);
						strobe = 1'b1; status = ST_OK; last = 1'b1; st_d = S_IDLE;
					end
					CMD_MODIFY: begin
						bk_d = bucket_of(exp_q, tick_q, idx0_q); st_d = S_PLACE_RD;
					end
					default: begin
						// expiry of head of current bucket
						live_d[id_q] = 1'b0; livecnt_d = livecnt_q - IW'(1);
						t_ra = sa(id_q); st_d = S_EMIT_NX;
					end
				endcase
			end
			S_EMIT_NX: st_d = S_EMIT_NWT;
			S_EMIT_NWT: begin
				// keep the expired timer until it is known whether it is the final one
				nid_d = id_q; tag_d = t_rd;
				emitn_d = emitn_q + 7'd1;
				bk_d = BW'(idx0_q); st_d = S_EMIT_RD;
			end
			S_UNL_DONE: begin
				case (cmd_q)
					CMD_GET: begin
						strobe = 1'b1; status = ST_OK; result_id = id_q; result_tag = t_rd;
						last = 1'b1; st_d = S_IDLE;
					end
					CMD_ADD: begin
						strobe = 1'b1; status = ST_OK; result_id = id_q; last = 1'b1;
						st_d = S_IDLE;
					end
					CMD_MODIFY: begin
						strobe = 1'b1; status = ST_OK; last = 1'b1; st_d = S_IDLE;
					end
					default: begin
						// cascade: go on with the next timer of the old list
						id_d = nid_q; st_d = S_CAS_NEXT;
					end
				endcase
			end
			S_CAS_RD: begin
				// read head of the cascading bucket and clear it
				bk_d = casb; b_ra = casb; st_d = S_CAS_WT;
			end
			S_CAS_WT: begin
				b_we = 1'b1; b_wa = bk_q; b_wd = '0;
				id_d = b_first; st_d = S_CAS_NEXT;
			end
			S_CAS_NEXT: begin
				if (id_q != '0) begin
					// placement of a cascaded timer needs its word first
					s_ra = sa(id_q); st_d = S_EMIT_WT;
				end else begin
					idxu_d[uix] = idxu_q[uix] + UPPER_LEVEL_BITS'(1);
					if (idxu_q[uix] + UPPER_LEVEL_BITS'(1) == UPPER_LEVEL_BITS'(1)
						&& lvl_q != LW'(LEVEL_COUNT - 1)) begin
						lvl_d = lvl_q + LW'(1); st_d = S_CAS_RD;
					end else begin
						bk_d = BW'(idx0_q); st_d = S_EMIT_RD;
					end
				end
			end
			S_EMIT_WT: begin
				// cascaded timer word: re-place it
				nid_d = rd_next; exp_d = rd_exp;
				bk_d = bucket_of(rd_exp, tick_q, idx0_q);
				st_d = S_PLACE_RD;
			end
			S_EMIT_RD: begin
				b_ra = bk_q; st_d = S_TICK_END;
			end
			S_TICK_END: begin
				if (b_first != '0 && emitn_q < 7'(POOL_SIZE)) begin
					if (emitn_q != '0) begin
						strobe = 1'b1; status = ST_EXPIRED; result_id = nid_q;
						result_tag = tag_q;
					end
					id_d = b_first; s_ra = sa(b_first); st_d = S_UNL_P;
					cmd_d = CMD_TICK;
				end else begin
					tick_d = tick_q + 32'd1; idx0_d = idx0_q + FIRST_LEVEL_BITS'(1);
					st_d = S_IDLE;
					strobe = 1'b1; last = 1'b1;
					if (emitn_q == '0) begin
						status = ST_EMPTY_TICK;
					end else begin
						status = ST_EXPIRED; result_id = nid_q; result_tag = tag_q;
					end
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR; live_q <= '0; tick_q <= '0; idx0_q <= '0;
			for (int i = 0; i < LEVEL_COUNT - 1; i++) idxu_q[i] <= '0;
			lastid_q <= '0; livecnt_q <= '0; clr_q <= '0; cmd_q <= CMD_TICK; emitn_q <= '0;
		end else begin
			st_q <= st_d; live_q <= live_d; tick_q <= tick_d; idx0_q <= idx0_d;
			idxu_q <= idxu_d; lastid_q <= lastid_d; livecnt_q <= livecnt_d;
			clr_q <= clr_d; cmd_q <= cmd_d; emitn_q <= emitn_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d; nid_q <= nid_d; exp_q <= exp_d; tag_q <= tag_d; lvl_q <= lvl_d;
		bk_q <= bk_d; p_q <= p_d; n_q <= n_d;
	end
endmodule

// ----- rtl/htw_ram.sv -----
// generic single-port-write ram with registered read
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/htw_checker.sv -----
// port-level checks for the timer wheel, bound to the top level
module htw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [2:0]  status,
	input logic [6:0]  result_id,
	input logic        last
);
	import htw_pkg::*;
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !busy) else $error("busy after last result");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |-> !strobe) else $error("result without request");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> status <= ST_EMPTY_TICK) else $error("bad status code");
	a_empty_tick_id: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_EMPTY_TICK |-> result_id == '0 && last)
		else $error("empty tick result malformed");
endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (.clk, .arst_n, .start, .busy,
	.strobe, .status, .result_id, .last);
